[hdl/dgf_pkg.sv]
// Shared types and constants for the decimal glyph formatter.
`timescale 1ns / 1ps

package dgf_pkg;

  localparam int MAX_WIDTH        = 16;  // widest field in cells
  localparam int FRAMES           = 16;  // glyph sets; a 4-bit frame covers them all
  localparam int GLYPHS_PER_FRAME = 24;
  localparam int NEG_OFFSET       = 12;
  localparam int BLANK_CODE       = 10;
  localparam int MAX_DIGITS       = 10;  // decimal digits of a 32-bit magnitude

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE  = 2'd1;

  localparam logic [1:0] ALIGN_NONE   = 2'd0;
  localparam logic [1:0] ALIGN_LEFT   = 2'd1;
  localparam logic [1:0] ALIGN_CENTER = 2'd2;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd3;

  // Reciprocal of ten for an exact 32-bit divide: q = (t * RECIP10) >> 35.
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Classified item handed from front to back.
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  len;    // digits shown, 1..10
    logic [4:0]  total;  // cells emitted, 1..16
    logic [3:0]  start;  // first digit cell
    logic [3:0]  frame;
  } item_t;

endpackage

[hdl/dgf_queue.sv]
// Two-entry queue between the classifying front and the emitting back.
`timescale 1ns / 1ps

module dgf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dgf_pkg::item_t push_data,
  input  logic           pop,
  output dgf_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  dgf_pkg::item_t                 mem_r [dgf_pkg::QDEPTH];
  logic [dgf_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dgf_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dgf_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == dgf_pkg::QCNT_W'(dgf_pkg::QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dgf_pkg::QCNT_W'(dgf_pkg::QDEPTH)) else $error("queue count out of range");

endmodule

[hdl/dgf_front.sv]
// Front end: takes items, drops blanks, finds digit count and field layout.
`timescale 1ns / 1ps

module dgf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_value,
  input  logic                 in_blank,
  input  logic [3:0]           in_frame,
  input  logic [4:0]           field_width,
  input  logic [1:0]           align_mode,
  input  logic                 q_full,
  output logic                 q_push,
  output dgf_pkg::item_t       q_data
);

  // stage 1: sign and magnitude
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_neg_r;
  logic [31:0] s1_mag_r;
  logic [3:0]  s1_frame_r;
  logic        take;

  // stage 2 (combinational into the queue): length and layout
  logic [3:0]  raw_len;
  logic [3:0]  len;
  logic [4:0]  width;
  logic [4:0]  gap;

  localparam logic [31:0] POW10 [9] = '{
    32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  assign busy   = s1_valid_r && q_full;
  assign take   = start && !busy && !in_blank;
  assign q_push = s1_valid_r && !q_full;

  always_comb begin
    s1_valid_nxt = take || (s1_valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_neg_r   <= in_value[31];
      s1_mag_r   <= in_value[31] ? 32'(32'd0 - 32'(in_value)) : 32'(in_value);
      s1_frame_r <= in_frame;
    end
  end

  always_comb begin
    raw_len = 4'd1;
    for (int k = 0; k < 9; k++) begin
      if (s1_mag_r >= POW10[k]) begin
        raw_len = raw_len + 4'd1;
      end
    end

    if (field_width == 5'd0) begin
      width = 5'd1;
    end else if (field_width > 5'(dgf_pkg::MAX_WIDTH)) begin
      width = 5'(dgf_pkg::MAX_WIDTH);
    end else begin
      width = field_width;
    end

    len = (5'(raw_len) > width) ? width[3:0] : raw_len;
    gap = width - 5'(len);

    q_data.neg   = s1_neg_r;
    q_data.mag   = s1_mag_r;
    q_data.len   = len;
    q_data.frame = s1_frame_r;
    case (align_mode)
      dgf_pkg::ALIGN_NONE: begin
        q_data.total = 5'(len);
        q_data.start = 4'd0;
      end
      dgf_pkg::ALIGN_LEFT: begin
        q_data.total = width;
        q_data.start = 4'd0;
      end
      dgf_pkg::ALIGN_CENTER: begin
        q_data.total = width;
        q_data.start = gap[4:1];
      end
      default: begin
        q_data.total = width;
        q_data.start = gap[3:0];
      end
    endcase
  end

endmodule

[hdl/dgf_back.sv]
// Back end: digit conversion by reciprocal multiply, then cell emission.
`timescale 1ns / 1ps

module dgf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  dgf_pkg::item_t q_head,
  output logic           q_pop,
  output logic           out_strobe,
  output logic [8:0]     out_glyph_index,
  output logic [3:0]     out_cell_position,
  output logic           out_last_cell
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIG  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  dgf_pkg::item_t  item_r;
  logic [31:0]     t_r;
  logic [63:0]     prod_r;
  logic [3:0]      dcnt_r, dcnt_nxt;
  logic [4:0]      cell_r, cell_nxt;
  logic [3:0]      digits_r [dgf_pkg::MAX_DIGITS];

  logic            strobe_r;
  logic [8:0]      glyph_r;
  logic [3:0]      pos_r;
  logic            last_r;

  logic [28:0]     quot;
  logic [31:0]     quot10;
  logic [31:0]     rem_full;
  logic            is_last;
  logic            in_digit;
  logic [4:0]      dig_end;
  logic [4:0]      didx;
  logic [4:0]      code;
  logic [8:0]      glyph;

  assign quot     = prod_r[63:dgf_pkg::RECIP_SHIFT];
  assign quot10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = t_r - quot10;

  assign dig_end  = 5'(item_r.start) + 5'(item_r.len);
  assign in_digit = (cell_r >= 5'(item_r.start)) && (cell_r < dig_end);
  assign didx     = dig_end - 5'd1 - cell_r;
  assign is_last  = (cell_r == item_r.total - 5'd1);

  always_comb begin
    if (!in_digit) begin
      code = 5'(dgf_pkg::BLANK_CODE);
    end else if (item_r.neg) begin
      code = 5'(digits_r[didx[3:0]]) + 5'(dgf_pkg::NEG_OFFSET);
    end else begin
      code = 5'(digits_r[didx[3:0]]);
    end
    glyph = 9'(item_r.frame) * 9'(dgf_pkg::GLYPHS_PER_FRAME) + 9'(code);
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    cell_nxt  = cell_r;
    case (state_r)
      ST_IDLE: begin
        dcnt_nxt = 4'd0;
        cell_nxt = 5'd0;
        if (!q_empty) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        dcnt_nxt  = dcnt_r + 4'd1;
        state_nxt = (dcnt_nxt == item_r.len) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        cell_nxt = cell_r + 5'd1;
        if (is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      dcnt_r   <= 4'd0;
      cell_r   <= 5'd0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dcnt_r   <= dcnt_nxt;
      cell_r   <= cell_nxt;
      strobe_r <= (state_r == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
      t_r    <= q_head.mag;
    end
    if (state_r == ST_MUL) begin
      prod_r <= t_r * dgf_pkg::RECIP10;
    end
    if (state_r == ST_DIG) begin
      digits_r[dcnt_r] <= rem_full[3:0];
      t_r              <= 32'(quot);
    end
    if (state_r == ST_EMIT) begin
      glyph_r <= glyph;
      pos_r   <= cell_r[3:0];
      last_r  <= is_last;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_glyph_index   = glyph_r;
  assign out_cell_position = pos_r;
  assign out_last_cell     = strobe_r && last_r;

  a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_cell |=> out_strobe)
    else $error("cell run broken before last cell");
  a_cells_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_cell |=> out_cell_position == $past(out_cell_position) + 4'd1)
    else $error("cell position did not advance");
  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIG |-> dcnt_r < item_r.len)
    else $error("digit counter past length");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_MUL)
    else $error("pop did not start conversion");

endmodule

[hdl/decimal_glyph_formatter.sv]
// Top level: signed value to a left-to-right row of glyph indices.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// input     in         start / busy                   in_value, in_blank, in_frame
// result    out        out_strobe (one cycle, no hold) out_glyph_index, out_cell_position,
//                                                     out_last_cell
// config    in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// An input transfer happens when start is high and busy is low. Blank items are
// dropped at the front and give no cells.
// Per item the back end spends a multiply by the reciprocal of ten and then a
// remainder step on each shown digit, then emits one cell per cycle, and only
// then returns to idle to take the next item from the queue.
// The shared reciprocal multiplier sets the digit pace.
// A two-entry queue lets the front take up to three further items while the back
// works; busy rises only when both queue entries and the front stage are held.
// Reset (synchronous, rst_n low) empties the queue and sets field_width 1,
// align_mode 0. Results cannot be stalled; cfg_ready is always high.

module decimal_glyph_formatter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_value,
  input  logic                                in_blank,
  input  logic [3:0]                          in_frame,
  output logic                                out_strobe,
  output logic [8:0]                          out_glyph_index,
  output logic [3:0]                          out_cell_position,
  output logic                                out_last_cell,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dgf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dgf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [4:0]      field_width_r;
  logic [1:0]      align_mode_r;
  logic            cfg_xfer;

  logic            q_push, q_pop, q_empty, q_full;
  dgf_pkg::item_t  q_in, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Config registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= 5'd1;
      align_mode_r  <= dgf_pkg::ALIGN_NONE;
    end else if (cfg_xfer) begin
      if (cfg_index == dgf_pkg::REG_FIELD_WIDTH) begin
        field_width_r <= cfg_data[4:0];
      end else if (cfg_index == dgf_pkg::REG_ALIGN_MODE) begin
        align_mode_r <= cfg_data[1:0];
      end
    end
  end

  // Front: sign/magnitude, digit count, clamp and alignment layout.
  dgf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value    (in_value),
    .in_blank    (in_blank),
    .in_frame    (in_frame),
    .field_width (field_width_r),
    .align_mode  (align_mode_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  // Decouples the classifier from the slow digit/emit loop.
  dgf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: low digits first into a small digit file, then cells left to right.
  dgf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_strobe        (out_strobe),
    .out_glyph_index   (out_glyph_index),
    .out_cell_position (out_cell_position),
    .out_last_cell     (out_last_cell)
  );

endmodule

[tb/sv/decimal_glyph_formatter_tb.sv]
// Self-checking testbench for the decimal glyph formatter: directed and random values.
`timescale 1ns / 1ps

module decimal_glyph_formatter_tb;

  // Blank items leave no cells behind, so give the back end time to settle
  // after the last owed cell before touching the registers.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int RANDOM_ITEMS  = 430;
  localparam int CALM_ITEMS    = 50;   // tail of the run with no idling

  // Indexes past the two real registers; writes there must change nothing.
  localparam logic [dgf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [dgf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic signed [31:0] value;
    logic               blank;
    logic [3:0]         frame;
    bit                 drain_first;  // hold off until all cells so far are out
  } disp_req_t;

  typedef struct {
    logic [8:0] glyph;
    logic [3:0] pos;
    logic       last;
  } cell_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           start     = 1'b0;
  logic                           busy;
  logic signed [31:0]             in_value  = '0;
  logic                           in_blank  = 1'b0;
  logic [3:0]                     in_frame  = '0;
  logic                           out_strobe;
  logic [8:0]                     out_glyph_index;
  logic [3:0]                     out_cell_position;
  logic                           out_last_cell;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dgf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dgf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  decimal_glyph_formatter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_value          (in_value),
    .in_blank          (in_blank),
    .in_frame          (in_frame),
    .out_strobe        (out_strobe),
    .out_glyph_index   (out_glyph_index),
    .out_cell_position (out_cell_position),
    .out_last_cell     (out_last_cell),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  // Requests waiting for the driver, and glyph cells still owed by the block.
  disp_req_t  pending_reqs[$];
  cell_t      cells_due[$];
  disp_req_t  cur_req;
  cell_t      cell_want;

  // Local copy of the register file, updated on each config transfer.
  logic [4:0] width_reg = 5'd1;
  logic [1:0] align_reg = dgf_pkg::ALIGN_NONE;

  int idle_pct       = 0;  // chance in percent of a gap burst after a transfer
  int gap_left       = 0;
  int mismatch_count = 0;

  // Turns one accepted request into the row of cells it should produce.
  function automatic void predict_cells(disp_req_t req);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] rest;
    int          width;
    int          len;
    int          total;
    int          first;
    int          fr;
    int          codes[dgf_pkg::MAX_WIDTH];
    cell_t       c;
    if (req.blank) return;
    neg = req.value[31];
    // Unsigned negate so the most negative value comes out as 2^31.
    mag = neg ? 32'd0 - req.value : req.value;
    width = (width_reg < 1) ? 1 :
            (width_reg > dgf_pkg::MAX_WIDTH) ? dgf_pkg::MAX_WIDTH : int'(width_reg);
    len  = 0;
    rest = mag;
    do begin
      len++;
      rest = rest / 10;
    end while (rest != 0);
    if (len > width) len = width;   // too long: keep the low digits
    total = (align_reg == dgf_pkg::ALIGN_NONE) ? len : width;
    case (align_reg)
      dgf_pkg::ALIGN_CENTER: first = (width - len) / 2;  // odd spare goes to the right
      dgf_pkg::ALIGN_RIGHT:  first = width - len;
      default:               first = 0;
    endcase
    for (int i = 0; i < total; i++) codes[i] = dgf_pkg::BLANK_CODE;
    rest = mag;
    for (int i = len; i > 0; i--) begin
      codes[first + i - 1] = (neg ? dgf_pkg::NEG_OFFSET : 0) + int'(rest % 10);
      rest = rest / 10;
    end
    fr = int'(req.frame) % dgf_pkg::FRAMES;
    for (int i = 0; i < total; i++) begin
      c.glyph = 9'((fr * dgf_pkg::GLYPHS_PER_FRAME + codes[i]) & 'h1FF);
      c.pos   = 4'(i);
      c.last  = (i == total - 1);
      cells_due.push_back(c);
    end
  endfunction

  function automatic void queue_req(logic signed [31:0] value, logic blank,
                                    logic [3:0] frame, bit drain_first);
    disp_req_t r;
    r.value       = value;
    r.blank       = blank;
    r.frame       = frame;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endfunction

  // One config transfer; leaves cfg_valid high so writes can go back to back.
  task automatic write_reg(input logic [dgf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dgf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dgf_pkg::REG_FIELD_WIDTH: width_reg = data;
      dgf_pkg::REG_ALIGN_MODE:  align_reg = data[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [4:0] fw,
                            input logic [dgf_pkg::CFG_DATA_W-1:0] align_data);
    write_reg(dgf_pkg::REG_FIELD_WIDTH, fw);
    write_reg(dgf_pkg::REG_ALIGN_MODE, align_data);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every request to go in and every owed cell to come out, then let
  // the back end settle so a register write cannot land mid-item.
  task automatic drain_pipeline();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || start || cells_due.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $display("%0t: drain stuck, %0d requests and %0d cells outstanding",
               $time, pending_reqs.size(), cells_due.size());
      mismatch_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: a transfer is start && !busy at the edge. While stalled, the
  // request and start stay put; otherwise the next step is computed once so
  // start only ever sees one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left  = 0;
    end else if (start && busy) begin
      // stalled: hold
    end else begin
      if (start) begin
        predict_cells(cur_req);
        if ($urandom_range(1, 100) <= idle_pct) gap_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        start    <= 1'b0;
        in_value <= $urandom;   // junk while idle
        in_blank <= 1'($urandom);
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && cells_due.size() != 0)) begin
        cur_req   = pending_reqs.pop_front();
        start    <= 1'b1;
        in_value <= cur_req.value;
        in_blank <= cur_req.blank;
        in_frame <= cur_req.frame;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: a cell is on the ports for exactly the cycle the strobe is high.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell: expected none, got glyph %0d pos %0d last %0d",
                 $time, out_glyph_index, out_cell_position, out_last_cell);
        mismatch_count++;
      end else begin
        cell_want = cells_due.pop_front();
        if (out_glyph_index !== cell_want.glyph || out_cell_position !== cell_want.pos ||
            out_last_cell !== cell_want.last) begin
          $display("%0t: cell mismatch: expected glyph %0d pos %0d last %0d, got %0d %0d %0d",
                   $time, cell_want.glyph, cell_want.pos, cell_want.last,
                   out_glyph_index, out_cell_position, out_last_cell);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int              made;
    int              span;
    int              i;
    int              digits;
    longint          lo;
    longint          hi;
    longint          mag;
    bit              neg;
    logic [4:0]      fw;
    logic signed [31:0] val;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 25;

    // Reset registers: one cell, no padding; only the units digit survives.
    queue_req(32'sd0, 1'b0, 4'd0, 1'b0);
    queue_req(-32'sd1, 1'b0, 4'd15, 1'b0);
    queue_req(32'sh7FFF_FFFF, 1'b0, 4'd7, 1'b0);
    queue_req(32'sd5, 1'b1, 4'd3, 1'b0);
    drain_pipeline();

    // Full width, right aligned; writes to the spare indexes must be ignored.
    write_reg(REG_SPARE_2, 5'd7);
    write_reg(REG_SPARE_3, 5'd31);
    set_config(5'd16, {3'b101, dgf_pkg::ALIGN_RIGHT});
    queue_req(32'sh8000_0000, 1'b0, 4'd15, 1'b1);  // most negative, shown as 2^31
    queue_req(32'sh7FFF_FFFF, 1'b0, 4'd0, 1'b0);
    queue_req(32'sd0, 1'b0, 4'd12, 1'b0);
    queue_req(-32'sd5, 1'b1, 4'd4, 1'b0);
    queue_req(32'sd123, 1'b0, 4'd3, 1'b0);
    drain_pipeline();

    // Width zero saturates to one cell.
    set_config(5'd0, {3'b000, dgf_pkg::ALIGN_CENTER});
    queue_req(32'sd42, 1'b0, 4'd1, 1'b0);
    queue_req(-32'sd7, 1'b0, 4'd2, 1'b0);
    drain_pipeline();

    // Width beyond the maximum saturates to sixteen.
    set_config(5'd31, {3'b111, dgf_pkg::ALIGN_LEFT});
    queue_req(32'sd12345, 1'b0, 4'd9, 1'b0);
    queue_req(-32'sd1, 1'b0, 4'd1, 1'b0);
    queue_req(32'sd1000000000, 1'b0, 4'd14, 1'b0);
    drain_pipeline();

    // Centering with zero, two and four spare cells, plus a clamped value.
    set_config(5'd5, {3'b010, dgf_pkg::ALIGN_CENTER});
    queue_req(32'sd999999999, 1'b0, 4'd5, 1'b0);
    queue_req(-32'sd100, 1'b0, 4'd6, 1'b0);
    queue_req(32'sd7, 1'b0, 4'd8, 1'b0);
    drain_pipeline();

    // Width ten, no padding: ten-digit magnitudes and one of nine digits.
    set_config(5'd10, {3'b000, dgf_pkg::ALIGN_NONE});
    queue_req(32'sh8000_0000, 1'b0, 4'd11, 1'b0);
    queue_req(32'sd1000000000, 1'b0, 4'd13, 1'b0);
    queue_req(-32'sd999999999, 1'b0, 4'd10, 1'b0);
    drain_pipeline();

    // Random phases, each with fresh register settings.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if (made != 0) drain_pipeline();
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 5'($urandom));
      case ($urandom_range(0, 9))
        0:       fw = 5'd0;
        1:       fw = 5'd31;
        2:       fw = 5'($urandom_range(17, 30));
        3:       fw = 5'd16;
        4:       fw = 5'd1;
        default: fw = 5'($urandom_range(1, 16));
      endcase
      set_config(fw, 5'($urandom));

      if (RANDOM_ITEMS - made <= CALM_ITEMS) begin
        idle_pct = 0;
        span     = RANDOM_ITEMS - made;
      end else begin
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        span     = $urandom_range(15, 40);
        if (span > RANDOM_ITEMS - CALM_ITEMS - made) span = RANDOM_ITEMS - CALM_ITEMS - made;
      end

      i = 0;
      while (i < span) begin
        neg = 1'($urandom);
        case ($urandom_range(0, 7))
          0, 1: val = $urandom;
          2, 3, 4: begin
            // magnitude with a chosen digit count
            digits = $urandom_range(1, 10);
            lo = 1;
            repeat (digits - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            mag = lo + longint'($urandom % (hi - lo + 1));
            val = 32'(neg ? -mag : mag);
          end
          5: begin
            // a power of ten or one below it
            digits = $urandom_range(1, 9);
            lo = 1;
            repeat (digits) lo = lo * 10;
            mag = lo - $urandom_range(0, 1);
            val = 32'(neg ? -mag : mag);
          end
          6: begin
            mag = $urandom_range(0, 99);
            val = 32'(neg ? -mag : mag);
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       val = 32'sh7FFF_FFFF;
              1:       val = 32'sh8000_0000;
              2:       val = 32'sd0;
              default: val = -32'sd1;
            endcase
          end
        endcase
        queue_req(val, $urandom_range(1, 100) <= 6, 4'($urandom),
                  $urandom_range(1, 100) == 1);
        if (!pending_reqs[$].blank) i++;
      end
      made += span;
    end

    drain_pipeline();
    if (cells_due.size() != 0) begin
      $display("%0t: %0d cells never arrived", $time, cells_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
